@@ hdl/dfc_pkg.sv @@
package dfc_pkg;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;
    localparam int COORD_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // input tuser
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_STEP    = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START_COL = 1'b1;

    // search directions, tried in this order with rotation
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    localparam logic SIDE_RIGHT  = 1'b0;
    localparam logic SIDE_BOTTOM = 1'b1;

    typedef enum logic [1:0] {
        EV_CARVED = 2'd0,
        EV_BACK   = 2'd1,
        EV_DONE   = 2'd2,
        EV_IDLE   = 2'd3
    } t_event;

    typedef struct packed {
        logic ok;    // neighbour lies inside the grid
        logic side;  // wall cleared if carved
    } t_nbr_flags;

    // result beat: wall_row, wall_col, wall_side, cur_row, cur_col from bit 0 up
    function automatic logic [OUT_DATA_W-1:0] pack_res(
        input logic [COORD_W-1:0] wall_row,
        input logic [COORD_W-1:0] wall_col,
        input logic               wall_side,
        input logic [COORD_W-1:0] cur_row,
        input logic [COORD_W-1:0] cur_col
    );
        return {7'd0, cur_col, cur_row, wall_side, wall_col, wall_row};
    endfunction

endpackage

@@ hdl/dfc_nbr.sv @@
module dfc_nbr #(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 16
) (
    input  logic [$clog2(GRID_ROWS)-1:0] i_row,
    input  logic [$clog2(GRID_COLS)-1:0] i_col,
    input  logic [1:0]                   i_dir,
    output logic [$clog2(GRID_ROWS)-1:0] o_nb_row,
    output logic [$clog2(GRID_COLS)-1:0] o_nb_col,
    output logic [$clog2(GRID_ROWS)-1:0] o_wall_row,
    output logic [$clog2(GRID_COLS)-1:0] o_wall_col,
    output dfc_pkg::t_nbr_flags          o_flags
);

    localparam int RB = $clog2(GRID_ROWS);
    localparam int CB = $clog2(GRID_COLS);
    localparam logic [RB-1:0] LAST_ROW = RB'(GRID_ROWS - 1);
    localparam logic [CB-1:0] LAST_COL = CB'(GRID_COLS - 1);

    always_comb begin
        o_nb_row     = i_row;
        o_nb_col     = i_col;
        o_wall_row   = i_row;
        o_wall_col   = i_col;
        o_flags.ok   = 1'b0;
        o_flags.side = dfc_pkg::SIDE_RIGHT;
        unique case (i_dir)
            dfc_pkg::DIR_UP: begin
                o_nb_row     = i_row - RB'(1);
                o_wall_row   = i_row - RB'(1);
                o_flags.ok   = (i_row != '0);
                o_flags.side = dfc_pkg::SIDE_BOTTOM;
            end
            dfc_pkg::DIR_LEFT: begin
                o_nb_col     = i_col - CB'(1);
                o_wall_col   = i_col - CB'(1);
                o_flags.ok   = (i_col != '0);
            end
            dfc_pkg::DIR_RIGHT: begin
                o_nb_col     = i_col + CB'(1);
                o_flags.ok   = (i_col != LAST_COL);
            end
            dfc_pkg::DIR_DOWN: begin
                o_nb_row     = i_row + RB'(1);
                o_flags.ok   = (i_row != LAST_ROW);
                o_flags.side = dfc_pkg::SIDE_BOTTOM;
            end
            default: ;
        endcase
    end

endmodule

@@ hdl/dfs_maze_carver.sv @@
// Depth-first maze carver. One input beat gives one result beat. A restart
// (tuser low) clears all 2^(RB+CB) entries of the visited map one cell a cycle,
// RB and CB being the row and column index widths (256 entries on the default
// 16x16 grid), then marks and pushes the start cell. A step (tuser high)
// probes the four neighbours one at a time through the single visited-map
// port, each neighbour inside the grid taking a probe state and a check state;
// a backtrack adds a pop state and, unless the path empties, a stack read
// state. A step with no maze in progress returns idle. The next beat is taken
// in the cycle after the result is loaded. Input is refused while an item is
// at work; a finished result waits in the output register while the next beat
// is taken. Start coordinates beyond the grid saturate.
module dfs_maze_carver #(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [dfc_pkg::IN_DATA_W-1:0]     i_s_tdata,  // rand_pick
    input  logic                              i_s_tuser,  // op
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // wall_row, wall_col, wall_side, cur_row, cur_col
    output logic [dfc_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic [1:0]                        o_m_tuser,  // event_res
    input  logic                              i_cfg_we,
    input  logic [dfc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dfc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int RB         = $clog2(GRID_ROWS);
    localparam int CB         = $clog2(GRID_COLS);
    localparam int AW         = RB + CB;
    localparam int MAP_DEPTH  = 1 << AW;
    localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
    localparam int SW         = $clog2(CELL_COUNT);
    localparam int DW         = $clog2(CELL_COUNT + 1);
    localparam int CW         = dfc_pkg::COORD_W;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CLEAR = 8'b0000_0010,
        ST_MARK  = 8'b0000_0100,
        ST_PROBE = 8'b0000_1000,
        ST_CHECK = 8'b0001_0000,
        ST_POP   = 8'b0010_0000,
        ST_POPRD = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_start_row, r_start_col;
    logic [RB-1:0] r_row, n_row;
    logic [CB-1:0] r_col, n_col;
    logic [DW-1:0] r_depth, n_depth;
    logic          r_running, n_running;
    logic [1:0]    r_pick, n_pick;
    logic [1:0]    r_k, n_k;
    logic [AW-1:0] r_clr, n_clr;
    logic [dfc_pkg::OUT_DATA_W-1:0] r_res_data, n_res_data;
    logic [1:0]    r_res_ev, n_res_ev;
    logic          r_m_valid, n_m_valid;
    logic [dfc_pkg::OUT_DATA_W-1:0] r_m_data, n_m_data;
    logic [1:0]    r_m_user, n_m_user;

    // visited map and path stack
    logic          vis_mem [MAP_DEPTH];
    logic          r_vis_rd;
    logic          vis_we, vis_wd;
    logic [AW-1:0] vis_addr;
    logic [AW-1:0] stk_mem [CELL_COUNT];
    logic [AW-1:0] r_stk_rd;
    logic          stk_we;
    logic [AW-1:0] stk_wd;
    logic [SW-1:0] stk_addr;

    logic [RB-1:0] nb_row, wall_row, sat_row;
    logic [CB-1:0] nb_col, wall_col, sat_col;
    dfc_pkg::t_nbr_flags nb_flags;
    logic [DW-1:0] depth_m2;
    logic          in_acc;

    dfc_nbr #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_nbr (
        .i_row      (r_row),
        .i_col      (r_col),
        .i_dir      (r_pick + r_k),
        .o_nb_row   (nb_row),
        .o_nb_col   (nb_col),
        .o_wall_row (wall_row),
        .o_wall_col (wall_col),
        .o_flags    (nb_flags)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign depth_m2   = r_depth - DW'(2);

    assign sat_row = (32'(r_start_row) >= GRID_ROWS) ? RB'(GRID_ROWS - 1) : RB'(r_start_row);
    assign sat_col = (32'(r_start_col) >= GRID_COLS) ? CB'(GRID_COLS - 1) : CB'(r_start_col);

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_depth    = r_depth;
        n_running  = r_running;
        n_pick     = r_pick;
        n_k        = r_k;
        n_clr      = r_clr;
        n_res_data = r_res_data;
        n_res_ev   = r_res_ev;
        n_m_valid  = r_m_valid && !i_m_tready;
        n_m_data   = r_m_data;
        n_m_user   = r_m_user;
        vis_we     = 1'b0;
        vis_wd     = 1'b0;
        vis_addr   = {nb_row, nb_col};
        stk_we     = 1'b0;
        stk_wd     = {nb_row, nb_col};
        stk_addr   = r_depth[SW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_s_tuser == dfc_pkg::OP_RESTART) begin
                        n_clr   = '0;
                        n_state = ST_CLEAR;
                    end else if (!r_running) begin
                        n_res_ev   = dfc_pkg::EV_IDLE;
                        n_res_data = '0;
                        n_state    = ST_FIN;
                    end else begin
                        n_pick  = i_s_tdata[1:0];
                        n_k     = 2'd0;
                        n_state = ST_PROBE;
                    end
                end
            end
            ST_CLEAR: begin
                vis_we   = 1'b1;
                vis_addr = r_clr;
                n_clr    = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_state = ST_MARK;
                end
            end
            ST_MARK: begin
                vis_we     = 1'b1;
                vis_wd     = 1'b1;
                vis_addr   = {sat_row, sat_col};
                stk_we     = 1'b1;
                stk_wd     = {sat_row, sat_col};
                stk_addr   = '0;
                n_row      = sat_row;
                n_col      = sat_col;
                n_depth    = DW'(1);
                n_running  = 1'b1;
                n_res_ev   = dfc_pkg::EV_IDLE;
                n_res_data = dfc_pkg::pack_res('0, '0, 1'b0, CW'(sat_row), CW'(sat_col));
                n_state    = ST_FIN;
            end
            ST_PROBE: begin
                // read of the neighbour's visited bit is issued here
                if (nb_flags.ok) begin
                    n_state = ST_CHECK;
                end else if (r_k == 2'd3) begin
                    n_state = ST_POP;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            ST_CHECK: begin
                if (!r_vis_rd) begin
                    vis_we     = 1'b1;
                    vis_wd     = 1'b1;
                    stk_we     = 1'b1;
                    n_depth    = r_depth + DW'(1);
                    n_row      = nb_row;
                    n_col      = nb_col;
                    n_res_ev   = dfc_pkg::EV_CARVED;
                    n_res_data = dfc_pkg::pack_res(CW'(wall_row), CW'(wall_col),
                                                   nb_flags.side, CW'(nb_row), CW'(nb_col));
                    n_state    = ST_FIN;
                end else if (r_k == 2'd3) begin
                    n_state = ST_POP;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_PROBE;
                end
            end
            ST_POP: begin
                n_depth  = r_depth - DW'(1);
                stk_addr = depth_m2[SW-1:0];
                if (r_depth == DW'(1)) begin
                    n_running  = 1'b0;
                    n_res_ev   = dfc_pkg::EV_DONE;
                    n_res_data = '0;
                    n_state    = ST_FIN;
                end else begin
                    n_state = ST_POPRD;
                end
            end
            ST_POPRD: begin
                n_row      = r_stk_rd[AW-1:CB];
                n_col      = r_stk_rd[CB-1:0];
                n_res_ev   = dfc_pkg::EV_BACK;
                n_res_data = dfc_pkg::pack_res('0, '0, 1'b0,
                                               CW'(r_stk_rd[AW-1:CB]), CW'(r_stk_rd[CB-1:0]));
                n_state    = ST_FIN;
            end
            ST_FIN: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_res_data;
                    n_m_user  = r_res_ev;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            vis_mem[vis_addr] <= vis_wd;
        end
        r_vis_rd <= vis_mem[vis_addr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_addr] <= stk_wd;
        end
        r_stk_rd <= stk_mem[stk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_depth     <= '0;
            r_running   <= 1'b0;
            r_m_valid   <= 1'b0;
            r_start_row <= 4'd15;
            r_start_col <= 4'd8;
        end else begin
            r_state   <= n_state;
            r_depth   <= n_depth;
            r_running <= n_running;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dfc_pkg::REG_START_ROW: r_start_row <= i_cfg_data;
                    dfc_pkg::REG_START_COL: r_start_col <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_pick     <= n_pick;
        r_k        <= n_k;
        r_clr      <= n_clr;
        r_res_data <= n_res_data;
        r_res_ev   <= n_res_ev;
        r_m_data   <= n_m_data;
        r_m_user   <= n_m_user;
    end

endmodule

@@ hdl/dfc_checker.sv @@
module dfc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [dfc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [1:0]                     o_m_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while an item is at work");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == dfc_pkg::EV_DONE |-> o_m_tdata == '0)
        else $error("finished beat carries coordinates");

    a_back_no_wall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == dfc_pkg::EV_BACK |-> o_m_tdata[8:0] == '0)
        else $error("backtrack beat reports a wall");

endmodule

bind dfs_maze_carver dfc_checker u_dfc_checker (.*);

@@ tb/tb_dfs_maze_carver.sv @@
`timescale 1ns / 1ps

module tb_dfs_maze_carver;

    localparam logic [dfc_pkg::COORD_W-1:0] LAST_ROW = 4'd15;
    localparam logic [dfc_pkg::COORD_W-1:0] LAST_COL = 4'd15;

    logic                           i_clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic [dfc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           m_tready = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [dfc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dfc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           o_s_tready;
    logic                           o_m_tvalid;
    logic [dfc_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic [1:0]                     o_m_tuser;

    bit no_idle = 1'b0;
    int n_items = 0;

    typedef struct packed {
        dfc_pkg::t_event             ev;
        logic [dfc_pkg::COORD_W-1:0] wall_row;
        logic [dfc_pkg::COORD_W-1:0] wall_col;
        logic                        wall_side;
        logic [dfc_pkg::COORD_W-1:0] cur_row;
        logic [dfc_pkg::COORD_W-1:0] cur_col;
    } t_move;

    class t_carve_tracker;
        bit                          visited [256];
        logic [7:0]                  path [256];
        int                          depth;
        bit                          running;
        logic [dfc_pkg::COORD_W-1:0] start_row;
        logic [dfc_pkg::COORD_W-1:0] start_col;
        t_move                       pending_moves [$];
        int                          bad;

        function new();
            foreach (visited[i]) visited[i] = 1'b0;
            depth     = 0;
            running   = 1'b0;
            start_row = 4'd15;
            start_col = 4'd8;
            bad       = 0;
        endfunction

        // predicts the result of one accepted beat and queues it
        function void note_beat(logic op, logic [1:0] pick);
            t_move                       m;
            logic [dfc_pkg::COORD_W-1:0] r, c, nr, nc;
            logic [1:0]                  d;
            bit                          open_dir [4];
            bit                          found;
            m     = '0;
            m.ev  = dfc_pkg::EV_IDLE;
            found = 1'b0;
            nr    = '0;
            nc    = '0;
            if (op == dfc_pkg::OP_RESTART) begin
                // 4-bit start registers cannot leave a 16x16 grid
                foreach (visited[i]) visited[i] = 1'b0;
                visited[{start_row, start_col}] = 1'b1;
                path[0]   = {start_row, start_col};
                depth     = 1;
                running   = 1'b1;
                m.cur_row = start_row;
                m.cur_col = start_col;
            end else if (!running) begin
                depth = 0;
            end else begin
                {r, c} = path[depth-1];
                open_dir[dfc_pkg::DIR_UP]    = (r != 4'd0)     && !visited[{r - 4'd1, c}];
                open_dir[dfc_pkg::DIR_LEFT]  = (c != 4'd0)     && !visited[{r, c - 4'd1}];
                open_dir[dfc_pkg::DIR_RIGHT] = (c != LAST_COL) && !visited[{r, c + 4'd1}];
                open_dir[dfc_pkg::DIR_DOWN]  = (r != LAST_ROW) && !visited[{r + 4'd1, c}];
                for (int k = 0; k < 4; k++) begin
                    d = pick + 2'(k);
                    if (!found && open_dir[d]) begin
                        found      = 1'b1;
                        nr         = r;
                        nc         = c;
                        m.wall_row = r;
                        m.wall_col = c;
                        case (d)
                            dfc_pkg::DIR_UP: begin
                                nr          = r - 4'd1;
                                m.wall_row  = r - 4'd1;
                                m.wall_side = dfc_pkg::SIDE_BOTTOM;
                            end
                            dfc_pkg::DIR_LEFT: begin
                                nc          = c - 4'd1;
                                m.wall_col  = c - 4'd1;
                                m.wall_side = dfc_pkg::SIDE_RIGHT;
                            end
                            dfc_pkg::DIR_RIGHT: begin
                                nc          = c + 4'd1;
                                m.wall_side = dfc_pkg::SIDE_RIGHT;
                            end
                            default: begin
                                nr          = r + 4'd1;
                                m.wall_side = dfc_pkg::SIDE_BOTTOM;
                            end
                        endcase
                    end
                end
                if (found) begin
                    visited[{nr, nc}] = 1'b1;
                    path[depth]       = {nr, nc};
                    depth++;
                    m.ev      = dfc_pkg::EV_CARVED;
                    m.cur_row = nr;
                    m.cur_col = nc;
                end else begin
                    depth--;
                    if (depth == 0) begin
                        running = 1'b0;
                        m.ev    = dfc_pkg::EV_DONE;
                    end else begin
                        m.ev = dfc_pkg::EV_BACK;
                        {m.cur_row, m.cur_col} = path[depth-1];
                    end
                end
            end
            pending_moves.push_back(m);
        endfunction

        function void check_move(logic [1:0] ev, logic [dfc_pkg::OUT_DATA_W-1:0] data);
            t_move got, want;
            got.ev        = dfc_pkg::t_event'(ev);
            got.wall_row  = data[3:0];
            got.wall_col  = data[7:4];
            got.wall_side = data[8];
            got.cur_row   = data[12:9];
            got.cur_col   = data[16:13];
            if (pending_moves.size() == 0) begin
                bad++;
                if (bad <= 10)
                    $display("unexpected result beat: event %0d data %h", ev, data);
                return;
            end
            want = pending_moves.pop_front();
            if (got !== want) begin
                bad++;
                if (bad <= 10)
                    $display({"mismatch: exp ev %0d wall %0d,%0d side %0d cur %0d,%0d",
                              " | got ev %0d wall %0d,%0d side %0d cur %0d,%0d"},
                             want.ev, want.wall_row, want.wall_col, want.wall_side,
                             want.cur_row, want.cur_col, got.ev, got.wall_row,
                             got.wall_col, got.wall_side, got.cur_row, got.cur_col);
            end
        endfunction
    endclass

    t_carve_tracker tracker;

    dfs_maze_carver uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(input logic op, input logic [1:0] pick);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(dfc_pkg::IN_DATA_W-2){1'b0}}, pick};
        s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        tracker.note_beat(op, pick);
        n_items++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending_moves.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_start(input logic [dfc_pkg::COORD_W-1:0] row,
                             input logic [dfc_pkg::COORD_W-1:0] col);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= dfc_pkg::REG_START_ROW;
        cfg_data  <= row;
        @(posedge i_clk);
        cfg_index <= dfc_pkg::REG_START_COL;
        cfg_data  <= col;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        tracker.start_row = row;
        tracker.start_col = col;
    endtask

    task automatic restart();
        send_beat(dfc_pkg::OP_RESTART, 2'($urandom_range(0, 3)));
    endtask

    task automatic step_any();
        send_beat(dfc_pkg::OP_STEP, 2'($urandom_range(0, 3)));
    endtask

    // result side: random stalls, plus long hold-offs to back the block up
    initial begin
        int stall;
        int hold;
        int n_results;
        stall     = 0;
        hold      = 0;
        n_results = 0;
        forever begin
            @(posedge i_clk);
            if (rst_n && m_tready && o_m_tvalid) begin
                tracker.check_move(o_m_tuser, o_m_tdata);
                n_results++;
                if (n_results == 150 || n_results == 1000)
                    hold = 600;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall = gap_len();
            end
        end
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int phase;
        logic [dfc_pkg::COORD_W-1:0] row, col;
        tracker = new();
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // steps before any restart are idle
        send_beat(dfc_pkg::OP_STEP, dfc_pkg::DIR_UP);
        send_beat(dfc_pkg::OP_STEP, dfc_pkg::DIR_DOWN);
        // reset start cell, bottom edge
        restart();
        send_beat(dfc_pkg::OP_STEP, dfc_pkg::DIR_UP);
        send_beat(dfc_pkg::OP_STEP, dfc_pkg::DIR_LEFT);
        send_beat(dfc_pkg::OP_STEP, dfc_pkg::DIR_RIGHT);
        send_beat(dfc_pkg::OP_STEP, dfc_pkg::DIR_DOWN);
        send_beat(dfc_pkg::OP_STEP, dfc_pkg::DIR_DOWN);
        send_beat(dfc_pkg::OP_STEP, dfc_pkg::DIR_LEFT);
        restart();
        // top-left corner: up and left blocked, so the pick rotates
        set_start(4'd0, 4'd0);
        restart();
        send_beat(dfc_pkg::OP_STEP, dfc_pkg::DIR_UP);
        send_beat(dfc_pkg::OP_STEP, dfc_pkg::DIR_DOWN);
        send_beat(dfc_pkg::OP_STEP, dfc_pkg::DIR_LEFT);
        send_beat(dfc_pkg::OP_STEP, dfc_pkg::DIR_UP);
        // bottom-right corner
        set_start(LAST_ROW, LAST_COL);
        restart();
        send_beat(dfc_pkg::OP_STEP, dfc_pkg::DIR_RIGHT);
        send_beat(dfc_pkg::OP_STEP, dfc_pkg::DIR_DOWN);

        phase = 0;
        while (n_items < 1500) begin
            case (phase % 6)
                0: begin row = 4'd0;  col = 4'd0;  end
                1: begin row = 4'd15; col = 4'd15; end
                2: begin row = 4'd0;  col = 4'd15; end
                3: begin row = 4'd15; col = 4'd0;  end
                4: begin row = 4'd15; col = 4'd8;  end
                default: begin
                    row = 4'($urandom_range(0, 15));
                    col = 4'($urandom_range(0, 15));
                end
            endcase
            set_start(row, col);
            no_idle = ($urandom_range(0, 3) == 0);
            restart();
            if (phase % 2 == 0) begin
                // carve the whole maze, then poke it once it is done
                while (tracker.running && n_items < 1500) step_any();
                repeat ($urandom_range(1, 2)) step_any();
            end else begin
                repeat ($urandom_range(10, 150)) begin
                    if ($urandom_range(0, 19) == 0)
                        restart();
                    else
                        step_any();
                end
            end
            phase++;
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (tracker.bad == 0 && tracker.pending_moves.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
